// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared widths and types for the triangle cotangent weights core
// Fixed field widths, internal word sizes and the record that travels from
// the front end to the root back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int W_COORD = 32;               // Q16.16 coordinate and weight
	localparam int W_DIFF  = W_COORD + 1;      // edge vector component
	localparam int W_PROD  = 2 * W_DIFF;       // product of two components
	localparam int W_CROSS = W_PROD + 1;       // cross product component
	localparam int W_DOT   = W_PROD + 2;       // dot product of an edge pair
	localparam int W_MAG   = W_PROD;           // magnitude of cross or dot
	localparam int W_LO    = 32;               // low half for split squaring
	localparam int W_HI    = W_MAG - W_LO;     // high half for split squaring
	localparam int W_SQ    = 2 * W_MAG;        // square of a magnitude
	localparam int W_S2    = W_SQ + 2;         // squared cross length
	localparam int T_SHIFT = 30;               // 2^30 scale on the squared dot
	localparam int W_T     = W_SQ + T_SHIFT;   // scaled squared dot
	localparam int N_ROOT  = 32;               // bits of the root
	localparam int W_ACC   = 200;              // root recurrence word
	localparam int N_LANE  = 3;                // one lane per corner

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [W_COORD-1:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [W_COORD-1:0] Q_MIN_MAG = 32'h8000_0000;

	typedef struct packed {
		logic [W_S2-1:0]            s2;
		logic [N_LANE-1:0][W_T-1:0] t;
		logic [N_LANE-1:0]          neg;
		logic                       degen;
	} tri_item_t;

endpackage

// ----- rtl/core/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: geometry front end
// Forms edge vectors, cross and dot products, their squares and the
// degenerate flag in seven pipeline stages, then pushes into the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [W_COORD-1:0] ax,
	input  logic signed [W_COORD-1:0] ay,
	input  logic signed [W_COORD-1:0] az,
	input  logic signed [W_COORD-1:0] bx,
	input  logic signed [W_COORD-1:0] by_coord,
	input  logic signed [W_COORD-1:0] bz,
	input  logic signed [W_COORD-1:0] cx,
	input  logic signed [W_COORD-1:0] cy,
	input  logic signed [W_COORD-1:0] cz,
	output logic                      push,
	output tri_item_t                 item,
	input  logic                      full
);

	logic signed [W_COORD-1:0] pa [3];
	logic signed [W_COORD-1:0] pb [3];
	logic signed [W_COORD-1:0] pc [3];
	logic                      en;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [W_DIFF-1:0]  u_s1 [3];
	logic signed [W_DIFF-1:0]  v_s1 [3];
	logic signed [W_DIFF-1:0]  w_s1 [3];
	logic signed [W_PROD-1:0]  xp_s2 [6];
	logic signed [W_PROD-1:0]  dp_s2 [N_LANE][3];
	logic signed [W_CROSS-1:0] cross_s3 [3];
	logic signed [W_DOT-1:0]   dot_s3 [N_LANE];
	logic signed [W_DOT-1:0]   dsum [N_LANE];
	logic [W_MAG-1:0]          mag_s4 [6];
	logic [N_LANE-1:0]         neg_s4, neg_s5, neg_s6;
	logic                      degen_s4, degen_s5, degen_s6;
	logic [2*W_HI-1:0]         hh_s5 [6];
	logic [W_HI+W_LO-1:0]      hl_s5 [6];
	logic [2*W_LO-1:0]         ll_s5 [6];
	logic [W_SQ-1:0]           sq_s6 [6];
	tri_item_t                 item_s7;

	assign pa[0] = ax; assign pa[1] = ay;       assign pa[2] = az;
	assign pb[0] = bx; assign pb[1] = by_coord; assign pb[2] = bz;
	assign pc[0] = cx; assign pc[1] = cy;       assign pc[2] = cz;

	assign en       = !vld_s7 || !full;
	assign in_ready = en;
	assign push     = vld_s7 && !full;
	assign item     = item_s7;

	// Corner B uses (c-b).(a-b), the negated dot of w = c-b with u = b-a.
	always_comb begin
		for (int l = 0; l < N_LANE; l++) begin
			dsum[l] = W_DOT'(dp_s2[l][0]) + W_DOT'(dp_s2[l][1]) + W_DOT'(dp_s2[l][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				u_s1[j] <= {pb[j][W_COORD-1], pb[j]} - {pa[j][W_COORD-1], pa[j]};
				v_s1[j] <= {pc[j][W_COORD-1], pc[j]} - {pa[j][W_COORD-1], pa[j]};
				w_s1[j] <= {pc[j][W_COORD-1], pc[j]} - {pb[j][W_COORD-1], pb[j]};
			end

			xp_s2[0] <= u_s1[1] * v_s1[2];
			xp_s2[1] <= u_s1[2] * v_s1[1];
			xp_s2[2] <= u_s1[2] * v_s1[0];
			xp_s2[3] <= u_s1[0] * v_s1[2];
			xp_s2[4] <= u_s1[0] * v_s1[1];
			xp_s2[5] <= u_s1[1] * v_s1[0];
			for (int j = 0; j < 3; j++) begin
				dp_s2[0][j] <= u_s1[j] * v_s1[j];
				dp_s2[1][j] <= w_s1[j] * u_s1[j];
				dp_s2[2][j] <= v_s1[j] * w_s1[j];
			end

			for (int j = 0; j < 3; j++) begin
				cross_s3[j] <= W_CROSS'(xp_s2[2*j]) - W_CROSS'(xp_s2[2*j+1]);
			end
			dot_s3[0] <= dsum[0];
			dot_s3[1] <= -dsum[1];
			dot_s3[2] <= dsum[2];

			for (int j = 0; j < 3; j++) begin
				mag_s4[j] <= W_MAG'(cross_s3[j][W_CROSS-1] ? -cross_s3[j] : cross_s3[j]);
			end
			for (int l = 0; l < N_LANE; l++) begin
				mag_s4[3+l] <= W_MAG'(dot_s3[l][W_DOT-1] ? -dot_s3[l] : dot_s3[l]);
				neg_s4[l]   <= dot_s3[l][W_DOT-1];
			end
			degen_s4 <= (cross_s3[0] == '0) && (cross_s3[1] == '0) && (cross_s3[2] == '0);

			// Squares are split into high and low halves to keep each multiply narrow.
			for (int k = 0; k < 6; k++) begin
				hh_s5[k] <= mag_s4[k][W_MAG-1:W_LO] * mag_s4[k][W_MAG-1:W_LO];
				hl_s5[k] <= mag_s4[k][W_MAG-1:W_LO] * mag_s4[k][W_LO-1:0];
				ll_s5[k] <= mag_s4[k][W_LO-1:0] * mag_s4[k][W_LO-1:0];
			end
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;

			for (int k = 0; k < 6; k++) begin
				sq_s6[k] <= (W_SQ'(hh_s5[k]) << (2 * W_LO)) + (W_SQ'(hl_s5[k]) << (W_LO + 1))
				            + W_SQ'(ll_s5[k]);
			end
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;

			item_s7.s2 <= W_S2'(sq_s6[0]) + W_S2'(sq_s6[1]) + W_S2'(sq_s6[2]);
			for (int l = 0; l < N_LANE; l++) begin
				item_s7.t[l] <= W_T'(sq_s6[3+l]) << T_SHIFT;
			end
			item_s7.neg   <= neg_s6;
			item_s7.degen <= degen_s6;
		end
	end

endmodule

// ----- rtl/core/tcw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue: short queue between front end and back end
// Circular buffer with a fill count; head entry is visible when not empty.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tri_item_t din,
	output logic      full,
	input  logic      pop,
	output tri_item_t dout,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tri_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- rtl/core/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back: root back end
// Pipelined restoring root, one result bit per stage in each of three lanes,
// followed by sign, saturation and the output register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  tri_item_t                 head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [W_COORD-1:0] cot_a,
	output logic signed [W_COORD-1:0] cot_b,
	output logic signed [W_COORD-1:0] cot_c,
	output logic                      degenerate,
	output logic                      saturated
);

	logic                en;
	logic [N_ROOT:0]     vld_s;
	logic [W_ACC-1:0]    rem_s  [N_ROOT][N_LANE];
	logic [W_ACC-1:0]    prod_s [N_ROOT][N_LANE];
	logic [N_ROOT-1:0]   root_s [N_ROOT+1][N_LANE];
	logic [W_S2-1:0]     s2_s   [N_ROOT];
	logic [N_LANE-1:0]   neg_s  [N_ROOT+1];
	logic                degen_s [N_ROOT+1];

	logic                out_valid_q;
	logic [W_COORD-1:0]  cot_q [N_LANE];
	logic                degen_q, sat_q;
	logic [W_COORD-1:0]  wt [N_LANE];
	logic [N_LANE-1:0]   lane_sat;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[N_ROOT-1:0], !empty};
			out_valid_q <= vld_s[N_ROOT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < N_LANE; l++) begin
				rem_s[0][l]  <= W_ACC'(head.t[l]);
				prod_s[0][l] <= '0;
				root_s[0][l] <= '0;
			end
			s2_s[0]    <= head.s2;
			neg_s[0]   <= head.neg;
			degen_s[0] <= head.degen;
		end
	end

	// Stage i decides root bit B. The remainder holds T - k*k*s2 and the
	// product holds k*s2, so setting bit B costs 2^(B+1)*k*s2 + 4^B*s2.
	for (genvar i = 0; i < N_ROOT; i++) begin : g_step
		localparam int B = N_ROOT - 1 - i;
		for (genvar l = 0; l < N_LANE; l++) begin : g_lane
			logic [W_ACC-1:0] delta;
			logic             take;
			assign delta = (prod_s[i][l] << (B + 1)) + (W_ACC'(s2_s[i]) << (2 * B));
			assign take  = (delta <= rem_s[i][l]);
			always_ff @(posedge clk) begin
				if (en) begin
					root_s[i+1][l] <= root_s[i][l] | (N_ROOT'(take) << B);
				end
			end
			// The last stage only needs its root bit.
			if (i < N_ROOT - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[i+1][l]  <= take ? rem_s[i][l] - delta : rem_s[i][l];
						prod_s[i+1][l] <= take ? prod_s[i][l] + (W_ACC'(s2_s[i]) << B)
						                       : prod_s[i][l];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1]   <= neg_s[i];
				degen_s[i+1] <= degen_s[i];
			end
		end
		if (i < N_ROOT - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					s2_s[i+1] <= s2_s[i];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < N_LANE; l++) begin
			if (neg_s[N_ROOT][l]) begin
				lane_sat[l] = (root_s[N_ROOT][l] > Q_MIN_MAG);
				wt[l]       = lane_sat[l] ? Q_MIN_MAG : W_COORD'(0) - root_s[N_ROOT][l];
			end else begin
				lane_sat[l] = (root_s[N_ROOT][l] > Q_MAX);
				wt[l]       = lane_sat[l] ? Q_MAX : root_s[N_ROOT][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < N_LANE; l++) begin
				cot_q[l] <= degen_s[N_ROOT] ? '0 : wt[l];
			end
			degen_q <= degen_s[N_ROOT];
			sat_q   <= !degen_s[N_ROOT] && (lane_sat != '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign cot_a      = cot_q[0];
	assign cot_b      = cot_q[1];
	assign cot_c      = cot_q[2];
	assign degenerate = degen_q;
	assign saturated  = sat_q;

endmodule

// ----- rtl/core/triangle_cotangent_weights_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_cotangent_weights_core: half cotangent weights of a 3D triangle
// Takes three Q16.16 corners per request and returns the half cotangent at
// each corner, exact to truncation, saturated to Q16.16.
// ----------------------------------------------------------------------------
// The core accepts one triangle request per clock and returns one result per
// clock in the same order while out_ready is high; a held output stalls the
// back end, and a full queue then stalls the front end. Each weight is
// half of dot(u,v) / |u x v| for the edge pair u, v leaving the corner, computed
// exactly in integer arithmetic and truncated toward zero. A triangle whose
// cross product is zero returns zero weights with degenerate set. Saturated
// is set when any weight is clamped. Data passes the geometry front end,
// the queue, the root back end and the output register in order. The root
// recurrence is fully pipelined, 32 stages, one per result bit, in three
// lanes, one per corner, and takes a new request per clock unless stalled.
// ----------------------------------------------------------------------------
module triangle_cotangent_weights_core import tcw_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [W_COORD-1:0] ax,
	input  logic signed [W_COORD-1:0] ay,
	input  logic signed [W_COORD-1:0] az,
	input  logic signed [W_COORD-1:0] bx,
	input  logic signed [W_COORD-1:0] by_coord,
	input  logic signed [W_COORD-1:0] bz,
	input  logic signed [W_COORD-1:0] cx,
	input  logic signed [W_COORD-1:0] cy,
	input  logic signed [W_COORD-1:0] cz,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [W_COORD-1:0] cot_a,
	output logic signed [W_COORD-1:0] cot_b,
	output logic signed [W_COORD-1:0] cot_c,
	output logic                      degenerate,
	output logic                      saturated
);

	// Front end to queue.
	logic      q_push, q_full;
	tri_item_t q_din;

	// Queue to back end.
	logic      q_pop, q_empty;
	tri_item_t q_dout;

	// The front end stalls only when the queue is full, and the back end
	// stalls only when the output register is held, so each side absorbs
	// the other's hiccups through the queue.
	tcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ax       (ax),
		.ay       (ay),
		.az       (az),
		.bx       (bx),
		.by_coord (by_coord),
		.bz       (bz),
		.cx       (cx),
		.cy       (cy),
		.cz       (cz),
		.push     (q_push),
		.item     (q_din),
		.full     (q_full)
	);

	tcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (q_dout),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cot_a      (cot_a),
		.cot_b      (cot_b),
		.cot_c      (cot_c),
		.degenerate (degenerate),
		.saturated  (saturated)
	);

endmodule
